[rtl/jse_pkg.sv]
package jse_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CTRL_END  = 8'h20;

    localparam logic [2:0] LEN_PLAIN = 3'd1;
    localparam logic [2:0] LEN_SHORT = 3'd2;
    localparam logic [2:0] LEN_UNI   = 3'd6;
    localparam logic [2:0] LEN_CLOSE = 3'd1;

    // how the back end expands one text byte
    typedef enum logic [1:0] {
        K_PLAIN,
        K_SHORT,
        K_UNI,
        K_CLOSE
    } t_kind;

    typedef struct packed {
        logic       open;   // emit an opening quote first
        t_kind      kind;
        logic [7:0] data;   // plain byte, escape letter or control byte
    } t_cmd;

    function automatic t_cmd classify(input logic [7:0] b);
        t_cmd c;
        c.open = 1'b0;
        c.data = b;
        c.kind = K_PLAIN;
        case (b)
            CH_NUL:    c.kind = K_CLOSE;
            CH_QUOTE:  c.kind = K_SHORT;
            CH_BSLASH: c.kind = K_SHORT;
            CH_BS:     begin c.kind = K_SHORT; c.data = CH_LO_B; end
            CH_FF:     begin c.kind = K_SHORT; c.data = CH_LO_F; end
            CH_LF:     begin c.kind = K_SHORT; c.data = CH_LO_N; end
            CH_CR:     begin c.kind = K_SHORT; c.data = CH_LO_R; end
            CH_TAB:    begin c.kind = K_SHORT; c.data = CH_LO_T; end
            default:   c.kind = (b < CTRL_END) ? K_UNI : K_PLAIN;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        return (nib < 4'd10) ? (CH_ZERO + wide) : (CH_LO_A - 8'd10 + wide);
    endfunction

    function automatic logic [2:0] cmd_len(input t_cmd c);
        logic [2:0] body;
        case (c.kind)
            K_PLAIN: body = LEN_PLAIN;
            K_SHORT: body = LEN_SHORT;
            K_UNI:   body = LEN_UNI;
            K_CLOSE: body = LEN_CLOSE;
            default: body = LEN_PLAIN;
        endcase
        return body + {2'b00, c.open};
    endfunction

endpackage

[rtl/jse_if.sv]
interface jse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;

    modport source (output valid, output out_byte, output run_last, output string_done,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_done,
                    output ready);
endinterface

[rtl/jse_front.sv]
module jse_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jse_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output jse_pkg::t_cmd o_cmd
);
    import jse_pkg::*;

    logic r_string_open;
    logic n_string_open;
    t_cmd w_cmd;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        w_cmd      = classify(i_in.text_byte);
        w_cmd.open = !r_string_open;
    end
    assign o_cmd = w_cmd;

    always_comb begin
        n_string_open = r_string_open;
        if (o_push) begin
            n_string_open = (i_in.text_byte != CH_NUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_string_open <= 1'b0;
        end else begin
            r_string_open <= n_string_open;
        end
    end

endmodule

[rtl/jse_queue.sv]
module jse_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jse_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_valid,
    output jse_pkg::t_cmd o_head
);
    import jse_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_do_push, w_do_pop;

    assign o_full       = (r_count == FULL_CNT);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_do_push    = i_push && !o_full;
    assign w_do_pop     = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("command popped from empty queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == FULL_CNT) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

[rtl/jse_back.sv]
module jse_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  jse_pkg::t_cmd i_head,
    output logic          o_pop,
    jse_out_if.source     o_out
);
    import jse_pkg::*;

    logic [2:0] r_step, n_step;
    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_done;
    logic       w_load;
    logic       w_is_last;
    logic [2:0] w_body;
    logic [7:0] w_byte;
    logic       w_done;

    assign w_load    = i_head_valid && (!r_valid || o_out.ready);
    assign w_is_last = (r_step == cmd_len(i_head) - 3'd1);
    assign w_body    = r_step - {2'b00, i_head.open};
    assign o_pop     = w_load && w_is_last;

    // byte for the current step of the head command
    always_comb begin
        w_byte = CH_QUOTE;
        w_done = 1'b0;
        if (i_head.open && r_step == 3'd0) begin
            w_byte = CH_QUOTE;
        end else begin
            case (i_head.kind)
                K_PLAIN: w_byte = i_head.data;
                K_SHORT: w_byte = (w_body == 3'd0) ? CH_BSLASH : i_head.data;
                K_UNI: begin
                    case (w_body)
                        3'd0:    w_byte = CH_BSLASH;
                        3'd1:    w_byte = CH_LO_U;
                        3'd2:    w_byte = CH_ZERO;
                        3'd3:    w_byte = CH_ZERO;
                        3'd4:    w_byte = hex_char(i_head.data[7:4]);
                        default: w_byte = hex_char(i_head.data[3:0]);
                    endcase
                end
                K_CLOSE: begin
                    w_byte = CH_QUOTE;
                    w_done = 1'b1;
                end
                default: w_byte = CH_QUOTE;
            endcase
        end
    end

    always_comb begin
        n_step  = r_step;
        n_valid = r_valid;
        if (w_load) begin
            n_step  = w_is_last ? 3'd0 : r_step + 3'd1;
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_byte;
            r_last <= w_is_last;
            r_done <= w_done;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.run_last    = r_last;
    assign o_out.string_done = r_done;

`ifndef SYNTHESIS
    a_step_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != 3'd0) |-> i_head_valid)
        else $error("expansion in progress without a head command");
`endif

endmodule

[rtl/json_string_escaper.sv]
// JSON string escaper: text bytes come in one word each, a zero byte ending
// the string, and the bytes of the quoted, escaped literal go out one word
// each. run_last marks the final output word of each input word and
// string_done marks the closing quote. Plain text streams at one word per
// cycle while the output is ready; an input word that yields n output
// words (1 to 7: opening quote, two-byte escapes, \u00xx forms) is sent
// from the output register one word at a time, and the input keeps
// flowing until the small command queue between the classifier and the
// expander fills. Each byte goes through the queue to the output register.
module json_string_escaper #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jse_in_if.sink    i_in,
    jse_out_if.source o_out
);
    import jse_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_head_valid;
    t_cmd w_cmd;
    t_cmd w_head;

    jse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_cmd        (w_cmd),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    jse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out        (o_out)
    );

endmodule

[dv/tb_json_string_escaper.sv]
`timescale 1ns / 100ps

module tb_json_string_escaper;
    import jse_pkg::*;

    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS   = 230;
    localparam string HEX_DIGITS  = "0123456789abcdef";

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } t_lit_word;

    logic i_clk;
    logic i_rst_n;

    jse_in_if  in_if();
    jse_out_if out_if();

    json_string_escaper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_lit_word lit_q[$];      // expected literal words, oldest first
    bit        lit_open;      // predictor copy of the open-string flag
    int        err_cnt;
    int        sent_cnt;
    bit        tx_idle_en = 1'b1;
    bit        rx_idle_en = 1'b1;
    bit        hold_req   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // expected literal words caused by one accepted text byte
    function automatic void predict_literal(input logic [7:0] b);
        t_lit_word words[7];
        int        n;
        logic [7:0] esc;
        n   = 0;
        esc = CH_NUL;
        if (!lit_open) begin
            words[n] = '{CH_QUOTE, 1'b0, 1'b0};
            n++;
        end
        if (b == CH_NUL) begin
            words[n] = '{CH_QUOTE, 1'b0, 1'b1};
            n++;
            lit_open = 1'b0;
        end else begin
            lit_open = 1'b1;
            case (b)
                CH_QUOTE:  esc = CH_QUOTE;
                CH_BSLASH: esc = CH_BSLASH;
                CH_BS:     esc = CH_LO_B;
                CH_FF:     esc = CH_LO_F;
                CH_LF:     esc = CH_LO_N;
                CH_CR:     esc = CH_LO_R;
                CH_TAB:    esc = CH_LO_T;
                default:   esc = CH_NUL;
            endcase
            if (esc != CH_NUL) begin
                words[n]     = '{CH_BSLASH, 1'b0, 1'b0};
                words[n + 1] = '{esc, 1'b0, 1'b0};
                n += 2;
            end else if (b < CTRL_END) begin
                words[n]     = '{CH_BSLASH, 1'b0, 1'b0};
                words[n + 1] = '{CH_LO_U, 1'b0, 1'b0};
                words[n + 2] = '{CH_ZERO, 1'b0, 1'b0};
                words[n + 3] = '{CH_ZERO, 1'b0, 1'b0};
                words[n + 4] = '{HEX_DIGITS[b[7:4]], 1'b0, 1'b0};
                words[n + 5] = '{HEX_DIGITS[b[3:0]], 1'b0, 1'b0};
                n += 6;
            end else begin
                words[n] = '{b, 1'b0, 1'b0};
                n++;
            end
        end
        words[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++) lit_q.push_back(words[i]);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) predict_literal(in_if.text_byte);
    end

    always @(posedge i_clk) begin : lit_checker
        t_lit_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (lit_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected word: byte=%02h last=%0b done=%0b", $time,
                         out_if.out_byte, out_if.run_last, out_if.string_done);
            end else begin
                want = lit_q.pop_front();
                if (want.out_byte !== out_if.out_byte || want.run_last !== out_if.run_last
                    || want.string_done !== out_if.string_done) begin
                    err_cnt++;
                    $display("%0t: mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                             $time, want.out_byte, want.run_last, want.string_done,
                             out_if.out_byte, out_if.run_last, out_if.string_done);
                end
            end
        end
    end

    // output side: random idling, or a long hold when requested
    initial begin : lit_receiver
        int hold_left;
        hold_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_left = HOLD_CYCLES - 1;
                hold_req <= 1'b0;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= !(rx_idle_en && $urandom_range(0, 99) < 14);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, quiet);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_text_byte(input logic [7:0] b);
        if (tx_idle_en && $urandom_range(0, 99) < 14) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.text_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        sent_cnt++;
    endtask

    function automatic logic [7:0] rand_text_byte();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 8'($urandom_range(8'h20, 8'h7E));
        if (sel < 72) return 8'($urandom_range(1, 31));
        if (sel < 84) return $urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH;
        return 8'($urandom_range(8'h7F, 8'hFF));
    endfunction

    task automatic send_rand_string(input int max_len);
        int len;
        len = $urandom_range(0, max_len);
        repeat (len) send_text_byte(rand_text_byte());
        send_text_byte(CH_NUL);
    endtask

    // empty string, every escape, control and pass-through edge, opening cases
    task automatic test_directed();
        logic [7:0] seq[$] = '{CH_NUL, 8'h01, CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF,
                               CH_CR, CH_TAB, 8'h1F, 8'h10, 8'h1A, 8'h20, 8'h7F, 8'h80,
                               8'hFF, CH_NUL, CH_QUOTE, CH_NUL, 8'h41, CH_NUL, CH_NUL};
        foreach (seq[i]) send_text_byte(seq[i]);
    endtask

    // receiver holds off long enough for the block to back up into the input
    task automatic test_stall_fill();
        tx_idle_en <= 1'b0;
        rx_idle_en <= 1'b0;
        hold_req   <= 1'b1;
        repeat (24) send_text_byte(rand_text_byte());
        send_text_byte(CH_NUL);
    endtask

    task automatic test_no_idle();
        int stop_at;
        stop_at = sent_cnt + 40;
        tx_idle_en <= 1'b0;
        rx_idle_en <= 1'b0;
        while (sent_cnt < stop_at) send_rand_string(10);
    endtask

    task automatic test_random();
        tx_idle_en <= 1'b1;
        rx_idle_en <= 1'b1;
        while (sent_cnt < TARGET_ITEMS) send_rand_string(12);
    endtask

    initial begin
        err_cnt         = 0;
        sent_cnt        = 0;
        lit_open        = 1'b0;
        in_if.valid     = 1'b0;
        in_if.text_byte = 8'h00;
        i_rst_n         = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_stall_fill();
        test_no_idle();
        test_random();

        in_if.valid <= 1'b0;
        while (lit_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/jse_pkg.sv
rtl/jse_if.sv
rtl/jse_front.sv
rtl/jse_queue.sv
rtl/jse_back.sv
rtl/json_string_escaper.sv
dv/tb_json_string_escaper.sv
